// ----- rtl/core/rk4dc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rk4dc_pkg: shared types and codes of the decay-chain integrator
// Control word layout, micro-op codes and divider sizing used by the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package rk4dc_pkg;

    localparam int PC_W = 6;

    // Multiplier operand A select.
    localparam logic [3:0] MA_NONE = 4'd0;
    localparam logic [3:0] MA_Y0   = 4'd1;
    localparam logic [3:0] MA_Y1   = 4'd2;
    localparam logic [3:0] MA_D0   = 4'd3;
    localparam logic [3:0] MA_D1   = 4'd4;
    localparam logic [3:0] MA_D2   = 4'd5;
    localparam logic [3:0] MA_S0   = 4'd6;
    localparam logic [3:0] MA_S1   = 4'd7;
    localparam logic [3:0] MA_S2   = 4'd8;

    // Multiplier operand B select.
    localparam logic [1:0] MB_K1 = 2'd0;
    localparam logic [1:0] MB_K2 = 2'd1;
    localparam logic [1:0] MB_H  = 2'd2;

    // Write-back operations on the previous product or the lane registers.
    localparam logic [3:0] WB_NOP  = 4'd0;
    localparam logic [3:0] WB_A    = 4'd1;
    localparam logic [3:0] WB_B    = 4'd2;
    localparam logic [3:0] WB_DER  = 4'd3;
    localparam logic [3:0] WB_ACC1 = 4'd4;
    localparam logic [3:0] WB_ACC2 = 4'd5;
    localparam logic [3:0] WB_Y0   = 4'd6;
    localparam logic [3:0] WB_Y1   = 4'd7;
    localparam logic [3:0] WB_Y2   = 4'd8;
    localparam logic [3:0] WB_T0   = 4'd9;
    localparam logic [3:0] WB_T1   = 4'd10;
    localparam logic [3:0] WB_T2   = 4'd11;
    localparam logic [3:0] WB_DIV  = 4'd12;
    localparam logic [3:0] WB_FIN  = 4'd13;
    localparam logic [3:0] WB_PUSH = 4'd14;

    // Sequencer jump kinds.
    localparam logic [2:0] J_NEXT    = 3'd0;
    localparam logic [2:0] J_IF_LOAD = 3'd1;
    localparam logic [2:0] J_LOOP    = 3'd2;
    localparam logic [2:0] J_GOTO    = 3'd3;
    localparam logic [2:0] J_END     = 3'd4;

    // Divide-by-six unit: quotient bits retired per pass and register width.
    localparam int DIV_BITS  = 8;
    localparam int T_W       = 40;
    localparam int DIV_STEPS = T_W / DIV_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [3:0]      mul_a;
        logic [1:0]      mul_b;
        logic [3:0]      wb;
        logic            stage_full;
        logic [2:0]      jump;
        logic [PC_W-1:0] target;
    } t_ctrl;

endpackage
`default_nettype wire

// ----- rtl/core/rk4dc_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rk4dc_seq: microcode sequencer
// Program counter, loop counter and the control-word ROM of one item.
// ----------------------------------------------------------------------------
module rk4dc_seq
    import rk4dc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_is_load,
    input  wire logic i_hold,
    output t_ctrl     o_ctrl,
    output logic      o_busy
);

    localparam logic [PC_W-1:0] A_PUSH = PC_W'(33);

    function automatic t_ctrl mk(input logic [3:0] ma, input logic [1:0] mb,
                                 input logic [3:0] wb, input logic full,
                                 input logic [2:0] jmp, input logic [PC_W-1:0] tgt);
        t_ctrl c;
        c.mul_a      = ma;
        c.mul_b      = mb;
        c.wb         = wb;
        c.stage_full = full;
        c.jump       = jmp;
        c.target     = tgt;
        return c;
    endfunction

    // Each word issues at most one multiply and may retire the product of the word before.
    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl c;
        case (pc)
            6'd0:  c = mk(MA_NONE, MB_K1, WB_NOP,  1'b0, J_IF_LOAD, A_PUSH);
            6'd1:  c = mk(MA_Y0,   MB_K1, WB_NOP,  1'b0, J_NEXT, '0);
            6'd2:  c = mk(MA_Y1,   MB_K2, WB_A,    1'b0, J_NEXT, '0);
            6'd3:  c = mk(MA_NONE, MB_K1, WB_B,    1'b0, J_NEXT, '0);
            6'd4:  c = mk(MA_NONE, MB_K1, WB_DER,  1'b0, J_NEXT, '0);
            6'd5:  c = mk(MA_D0,   MB_H,  WB_ACC1, 1'b0, J_NEXT, '0);
            6'd6:  c = mk(MA_D1,   MB_H,  WB_Y0,   1'b0, J_NEXT, '0);
            6'd7:  c = mk(MA_D2,   MB_H,  WB_Y1,   1'b0, J_NEXT, '0);
            6'd8:  c = mk(MA_Y0,   MB_K1, WB_Y2,   1'b0, J_NEXT, '0);
            6'd9:  c = mk(MA_Y1,   MB_K2, WB_A,    1'b0, J_NEXT, '0);
            6'd10: c = mk(MA_NONE, MB_K1, WB_B,    1'b0, J_NEXT, '0);
            6'd11: c = mk(MA_NONE, MB_K1, WB_DER,  1'b0, J_NEXT, '0);
            6'd12: c = mk(MA_D0,   MB_H,  WB_ACC2, 1'b0, J_NEXT, '0);
            6'd13: c = mk(MA_D1,   MB_H,  WB_Y0,   1'b0, J_NEXT, '0);
            6'd14: c = mk(MA_D2,   MB_H,  WB_Y1,   1'b0, J_NEXT, '0);
            6'd15: c = mk(MA_Y0,   MB_K1, WB_Y2,   1'b0, J_NEXT, '0);
            6'd16: c = mk(MA_Y1,   MB_K2, WB_A,    1'b0, J_NEXT, '0);
            6'd17: c = mk(MA_NONE, MB_K1, WB_B,    1'b0, J_NEXT, '0);
            6'd18: c = mk(MA_NONE, MB_K1, WB_DER,  1'b0, J_NEXT, '0);
            6'd19: c = mk(MA_D0,   MB_H,  WB_ACC2, 1'b0, J_NEXT, '0);
            6'd20: c = mk(MA_D1,   MB_H,  WB_Y0,   1'b1, J_NEXT, '0);
            6'd21: c = mk(MA_D2,   MB_H,  WB_Y1,   1'b1, J_NEXT, '0);
            6'd22: c = mk(MA_Y0,   MB_K1, WB_Y2,   1'b1, J_NEXT, '0);
            6'd23: c = mk(MA_Y1,   MB_K2, WB_A,    1'b0, J_NEXT, '0);
            6'd24: c = mk(MA_NONE, MB_K1, WB_B,    1'b0, J_NEXT, '0);
            6'd25: c = mk(MA_NONE, MB_K1, WB_DER,  1'b0, J_NEXT, '0);
            6'd26: c = mk(MA_NONE, MB_K1, WB_ACC1, 1'b0, J_NEXT, '0);
            6'd27: c = mk(MA_S0,   MB_H,  WB_NOP,  1'b0, J_NEXT, '0);
            6'd28: c = mk(MA_S1,   MB_H,  WB_T0,   1'b0, J_NEXT, '0);
            6'd29: c = mk(MA_S2,   MB_H,  WB_T1,   1'b0, J_NEXT, '0);
            6'd30: c = mk(MA_NONE, MB_K1, WB_T2,   1'b0, J_NEXT, '0);
            6'd31: c = mk(MA_NONE, MB_K1, WB_DIV,  1'b0, J_LOOP, '0);
            6'd32: c = mk(MA_NONE, MB_K1, WB_FIN,  1'b0, J_NEXT, '0);
            6'd33: c = mk(MA_NONE, MB_K1, WB_PUSH, 1'b0, J_END,  '0);
            default: c = mk(MA_NONE, MB_K1, WB_NOP, 1'b0, J_END, '0);
        endcase
        return c;
    endfunction

    logic            r_run;
    logic [PC_W-1:0] r_pc;
    logic [CNT_W-1:0] r_cnt;
    t_ctrl           w_word;

    assign w_word = rom_word(r_pc);
    assign o_ctrl = r_run ? w_word : mk(MA_NONE, MB_K1, WB_NOP, 1'b0, J_NEXT, '0);
    assign o_busy = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
            r_cnt <= CNT_W'(DIV_STEPS - 1);
        end else if (i_start) begin
            r_run <= 1'b1;
            r_pc  <= '0;
        end else if (r_run && !i_hold) begin
            if (w_word.jump != J_LOOP) begin
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end
            unique case (w_word.jump)
                J_NEXT: begin
                    r_pc <= r_pc + 1'b1;
                end
                J_IF_LOAD: begin
                    r_pc <= i_is_load ? w_word.target : r_pc + 1'b1;
                end
                J_LOOP: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                J_GOTO: begin
                    r_pc <= w_word.target;
                end
                default: begin
                    r_run <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rk4_two_stage_decay_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_two_stage_decay_chain: fixed-point RK4 step of a two-stage decay chain
// Holds x1, x2, x3 in signed Q16.16; a load item sets them, a step item
// advances them by one saturating fourth-order Runge-Kutta step.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_kind, i_load_first..third
//  result    out        o_out_valid / i_out_ready  o_value_first..third, o_saturated
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
//  A step item runs 34 microcode words through one 36x17 multiplier, the
//  divide-by-six word repeating 5 times; a load item runs only the first word
//  and the push word. One item is in work at a time; the next is taken while
//  the previous result waits in the output register. Reset is synchronous: rate
//  and step registers return to their defaults and the state to zero. A stalled
//  result holds the sequencer on its final word.
// ----------------------------------------------------------------------------
module rk4_two_stage_decay_chain
    import rk4dc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_kind,
    input  wire logic signed [31:0] i_load_first,
    input  wire logic signed [31:0] i_load_second,
    input  wire logic signed [31:0] i_load_third,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_value_first,
    output logic signed [31:0]      o_value_second,
    output logic signed [31:0]      o_value_third,
    output logic                    o_saturated,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    localparam logic [1:0]  CFG_RATE_FIRST  = 2'd0;
    localparam logic [1:0]  CFG_RATE_SECOND = 2'd1;
    localparam logic [1:0]  CFG_STEP_SIZE   = 2'd2;
    localparam logic [15:0] RATE_FIRST_RST  = 16'd37814;
    localparam logic [15:0] RATE_SECOND_RST = 16'd27656;
    localparam logic [15:0] STEP_SIZE_RST   = 16'd655;
    localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
    // Half of six in Q16, added before the divide by six.
    localparam logic [52:0] SIXTH_RND = 53'd196608;

    function automatic logic ovf32(input logic signed [35:0] v);
        return v[35:31] != {5{v[31]}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (ovf32(v)) begin
            return v[35] ? S32_MIN : S32_MAX;
        end
        return v[31:0];
    endfunction

    function automatic logic [52:0] mag53(input logic signed [52:0] p);
        return p[52] ? $unsigned(-p) : $unsigned(p);
    endfunction

    // Rounded shift by 16 or 17, nearest with ties away from zero.
    function automatic logic signed [33:0] rnd_shift(input logic signed [52:0] p,
                                                     input logic full);
        logic [52:0] v_sum;
        logic [52:0] v_q;
        v_sum = mag53(p) + (full ? 53'd32768 : 53'd65536);
        v_q   = full ? (v_sum >> 16) : (v_sum >> 17);
        return p[52] ? -$signed(v_q[33:0]) : $signed(v_q[33:0]);
    endfunction

    t_ctrl w_ctrl;
    logic  w_busy;
    logic  w_accept;
    logic  w_stall;
    logic  w_push;

    logic [15:0]        r_k1;
    logic [15:0]        r_k2;
    logic [15:0]        r_h;
    logic signed [31:0] r_x [3];
    logic signed [31:0] r_y [2];
    logic signed [31:0] r_d [3];
    logic signed [35:0] r_sum [3];
    logic [T_W-1:0]     r_t [3];
    logic [2:0]         r_rem [3];
    logic               r_neg [3];
    logic signed [33:0] r_a;
    logic signed [33:0] r_b;
    logic signed [52:0] r_prod;
    logic               r_kind;
    logic               r_clamp;
    logic               r_out_valid;
    logic signed [31:0] r_out_x [3];
    logic               r_out_sat;

    logic signed [35:0] w_ma;
    logic signed [16:0] w_mb;
    logic signed [33:0] w_rnd;
    logic [1:0]         w_lane;
    logic               w_is_stage;
    logic signed [35:0] w_stage_sum;
    logic signed [35:0] w_der_sum [3];
    logic signed [31:0] w_der [3];
    logic signed [35:0] w_fin_sum [3];
    logic [T_W-1:0]     w_tval;
    logic [T_W-1:0]     w_div_t [3];
    logic [2:0]         w_div_rem [3];
    logic               w_flag;

    rk4dc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_is_load (~r_kind),
        .i_hold    (w_stall),
        .o_ctrl    (w_ctrl),
        .o_busy    (w_busy)
    );

    assign o_in_ready = ~w_busy;
    assign w_accept   = i_in_valid & ~w_busy;
    assign w_stall    = (w_ctrl.wb == WB_PUSH) & r_out_valid & ~i_out_ready;
    assign w_push     = (w_ctrl.wb == WB_PUSH) & ~w_stall;

    always_comb begin
        unique case (w_ctrl.mul_a)
            MA_Y0:   w_ma = 36'(r_y[0]);
            MA_Y1:   w_ma = 36'(r_y[1]);
            MA_D0:   w_ma = 36'(r_d[0]);
            MA_D1:   w_ma = 36'(r_d[1]);
            MA_D2:   w_ma = 36'(r_d[2]);
            MA_S0:   w_ma = r_sum[0];
            MA_S1:   w_ma = r_sum[1];
            MA_S2:   w_ma = r_sum[2];
            default: w_ma = '0;
        endcase
        unique case (w_ctrl.mul_b)
            MB_K1:   w_mb = $signed({1'b0, r_k1});
            MB_K2:   w_mb = $signed({1'b0, r_k2});
            default: w_mb = $signed({1'b0, r_h});
        endcase
    end

    // Stage point: x plus the rounded step offset of one lane.
    always_comb begin
        unique case (w_ctrl.wb)
            WB_Y1:   w_lane = 2'd1;
            WB_Y2:   w_lane = 2'd2;
            default: w_lane = 2'd0;
        endcase
        w_is_stage  = (w_ctrl.wb == WB_Y0) || (w_ctrl.wb == WB_Y1) ||
                      (w_ctrl.wb == WB_Y2);
        w_rnd       = rnd_shift(r_prod, w_ctrl.stage_full);
        w_stage_sum = 36'(r_x[w_lane]) + 36'(w_rnd);
    end

    always_comb begin
        w_der_sum[0] = -36'(r_a);
        w_der_sum[1] = 36'(r_a) - 36'(r_b);
        w_der_sum[2] = 36'(r_b);
        for (int i = 0; i < 3; i++) begin
            w_der[i]     = sat32(w_der_sum[i]);
            w_fin_sum[i] = r_neg[i] ? 36'(r_x[i]) - $signed({3'b000, r_t[i][32:0]})
                                    : 36'(r_x[i]) + $signed({3'b000, r_t[i][32:0]});
        end
        w_tval = T_W'((mag53(r_prod) + SIXTH_RND) >> 16);
    end

    // Long division by six, DIV_BITS quotient bits per pass, in all three lanes.
    always_comb begin : p_div
        logic [3:0]     v_rem;
        logic [T_W-1:0] v_t;
        for (int i = 0; i < 3; i++) begin
            v_rem = {1'b0, r_rem[i]};
            v_t   = r_t[i];
            for (int j = 0; j < DIV_BITS; j++) begin
                v_rem = {v_rem[2:0], v_t[T_W-1]};
                v_t   = {v_t[T_W-2:0], 1'b0};
                if (v_rem >= 4'd6) begin
                    v_rem  = v_rem - 4'd6;
                    v_t[0] = 1'b1;
                end
            end
            w_div_t[i]   = v_t;
            w_div_rem[i] = v_rem[2:0];
        end
    end

    always_comb begin
        w_flag = 1'b0;
        if (w_ctrl.wb == WB_DER) begin
            w_flag = ovf32(w_der_sum[0]) | ovf32(w_der_sum[1]) | ovf32(w_der_sum[2]);
        end else if (w_is_stage) begin
            w_flag = ovf32(w_stage_sum);
        end else if (w_ctrl.wb == WB_FIN) begin
            w_flag = ovf32(w_fin_sum[0]) | ovf32(w_fin_sum[1]) | ovf32(w_fin_sum[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1        <= RATE_FIRST_RST;
            r_k2        <= RATE_SECOND_RST;
            r_h         <= STEP_SIZE_RST;
            r_clamp     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_x[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE_FIRST:  r_k1 <= i_cfg_data;
                    CFG_RATE_SECOND: r_k2 <= i_cfg_data;
                    CFG_STEP_SIZE:   r_h  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_clamp <= 1'b0;
                if (!i_kind) begin
                    r_x[0] <= i_load_first;
                    r_x[1] <= i_load_second;
                    r_x[2] <= i_load_third;
                end
            end else if (w_flag) begin
                r_clamp <= 1'b1;
            end
            if (w_ctrl.wb == WB_FIN) begin
                for (int i = 0; i < 3; i++) begin
                    r_x[i] <= sat32(w_fin_sum[i]);
                end
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_accept) begin
            r_kind <= i_kind;
            r_y[0] <= r_x[0];
            r_y[1] <= r_x[1];
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end
        unique case (w_ctrl.wb)
            WB_A:   r_a <= rnd_shift(r_prod, 1'b1);
            WB_B:   r_b <= rnd_shift(r_prod, 1'b1);
            WB_DER: begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= w_der[i];
                end
            end
            WB_ACC1: begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= r_sum[i] + 36'(r_d[i]);
                end
            end
            WB_ACC2: begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= r_sum[i] + (36'(r_d[i]) <<< 1);
                end
            end
            WB_Y0:  r_y[0] <= sat32(w_stage_sum);
            WB_Y1:  r_y[1] <= sat32(w_stage_sum);
            WB_T0: begin
                r_t[0]   <= w_tval;
                r_rem[0] <= '0;
                r_neg[0] <= r_prod[52];
            end
            WB_T1: begin
                r_t[1]   <= w_tval;
                r_rem[1] <= '0;
                r_neg[1] <= r_prod[52];
            end
            WB_T2: begin
                r_t[2]   <= w_tval;
                r_rem[2] <= '0;
                r_neg[2] <= r_prod[52];
            end
            WB_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_t[i]   <= w_div_t[i];
                    r_rem[i] <= w_div_rem[i];
                end
            end
            default: ;
        endcase
        if (w_push) begin
            for (int i = 0; i < 3; i++) begin
                r_out_x[i] <= r_x[i];
            end
            r_out_sat <= r_clamp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value_first  = r_out_x[0];
    assign o_value_second = r_out_x[1];
    assign o_value_third  = r_out_x[2];
    assign o_saturated    = r_out_sat;

endmodule
`default_nettype wire

// ----- rtl/core/rk4dc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rk4dc_checker: port-level checks of the decay-chain integrator
// Watches the handshakes and the load path from the top-level ports.
// ----------------------------------------------------------------------------
module rk4dc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               i_kind,
    input wire logic signed [31:0] i_load_first,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_value_first,
    input wire logic signed [31:0] o_value_second,
    input wire logic signed [31:0] o_value_third,
    input wire logic               o_saturated
);

    // A waiting result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_value_first) &&
            $stable(o_value_second) && $stable(o_value_third) && $stable(o_saturated)))
        else $error("result changed while stalled");

    // Only one item is in work: ready drops right after an item is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after an item was taken");

    // A result only appears while an item is in work.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without an item in work");

    // A load item taken with an empty output register returns its first value with no saturation flag.
    a_load_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_kind && !o_out_valid) |-> ##3
            (o_out_valid && o_value_first == $past(i_load_first, 3) && !o_saturated))
        else $error("load item returned wrong state");

endmodule

bind rk4_two_stage_decay_chain rk4dc_checker u_checker (.*);
`default_nettype wire
